// File: sv/fur_pkg.sv
package fur_pkg;

  localparam logic [7:0]  SYNC_FIRST  = 8'h55;
  localparam logic [7:0]  SYNC_SECOND = 8'hAA;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [10:0] MAX_LEN_RST = 11'd512;

  localparam logic [2:0] ADDR_MAX_LEN = 3'd0;

  typedef enum logic [2:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_LENHI,
    PH_LENLO,
    PH_DATA,
    PH_CRCHI,
    PH_CRCLO
  } fur_phase_t;

  typedef enum logic [2:0] {
    EV_NONE,
    EV_PAYLOAD,
    EV_GOOD,
    EV_CRC_ERR,
    EV_LEN_REJECT
  } fur_event_t;

  typedef struct packed {
    fur_event_t  kind;
    logic [7:0]  payload_byte;
    logic [9:0]  payload_offset;
    logic [10:0] frame_length;
    logic [23:0] flash_page_addr;
    logic        erase_first;
  } fur_result_t;

  // CRC-16/MODBUS, one byte, LSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: sv/fur_parser.sv
module fur_parser #(
  parameter int LEN_LIMIT_MAX = 1024,
  parameter int PAGE_STRIDE   = 256,
  parameter int ERASE_BLOCK   = 4096,
  parameter int ADDR_WIDTH    = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  input  logic [10:0]         max_len,
  output fur_pkg::fur_result_t res
);

  localparam int CNT_W = $clog2(LEN_LIMIT_MAX + 1);
  localparam int OFS_W = $clog2(ERASE_BLOCK);
  localparam int SUM_W = OFS_W + 2;
  localparam longint WRAP_MOD = (longint'(1) << ADDR_WIDTH) % ERASE_BLOCK;
  localparam logic [SUM_W-1:0] STRIDE_MOD = SUM_W'(PAGE_STRIDE % ERASE_BLOCK);
  localparam logic [SUM_W-1:0] WRAP_ADJ   = SUM_W'(ERASE_BLOCK - WRAP_MOD);
  localparam logic [SUM_W-1:0] EB_V       = SUM_W'(ERASE_BLOCK);
  localparam logic [15:0]      LIM_MAX    = 16'(LEN_LIMIT_MAX);
  localparam logic [ADDR_WIDTH:0] STRIDE_V = (ADDR_WIDTH + 1)'(PAGE_STRIDE);

  fur_pkg::fur_phase_t     phase_r, phase_nxt;
  logic [15:0]             len_r, len_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [15:0]             crc_r, crc_nxt;
  logic [7:0]              crc_hi_r, crc_hi_nxt;
  logic [ADDR_WIDTH-1:0]   addr_r, addr_nxt;
  logic [OFS_W-1:0]        ofs_r, ofs_nxt;

  logic [15:0]             crc_upd;
  logic [15:0]             len_full;
  logic [15:0]             limit;
  logic [CNT_W-1:0]        cnt_inc;
  logic [ADDR_WIDTH:0]     addr_sum;
  logic [SUM_W-1:0]        ofs_t0, ofs_t1, ofs_t2;

  always_comb begin
    crc_upd  = fur_pkg::crc16_byte(
                 (phase_r == fur_pkg::PH_LENHI) ? fur_pkg::CRC_INIT : crc_r, rx_byte);
    len_full = len_r | {8'h00, rx_byte};
    limit    = ({5'b0, max_len} > LIM_MAX) ? LIM_MAX : {5'b0, max_len};
    cnt_inc  = cnt_r + CNT_W'(1);
    addr_sum = {1'b0, addr_r} + STRIDE_V;
    ofs_t0   = {2'b00, ofs_r} + STRIDE_MOD + (addr_sum[ADDR_WIDTH] ? WRAP_ADJ : '0);
    ofs_t1   = (ofs_t0 >= EB_V) ? ofs_t0 - EB_V : ofs_t0;
    ofs_t2   = (ofs_t1 >= EB_V) ? ofs_t1 - EB_V : ofs_t1;
  end

  always_comb begin
    phase_nxt  = phase_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    crc_nxt    = crc_r;
    crc_hi_nxt = crc_hi_r;
    addr_nxt   = addr_r;
    ofs_nxt    = ofs_r;
    res        = '0;
    res.kind   = fur_pkg::EV_NONE;
    unique case (phase_r)
      fur_pkg::PH_SYNC1: begin
        if (rx_byte == fur_pkg::SYNC_FIRST) phase_nxt = fur_pkg::PH_SYNC2;
      end
      fur_pkg::PH_SYNC2: begin
        if (rx_byte == fur_pkg::SYNC_SECOND) phase_nxt = fur_pkg::PH_LENHI;
      end
      fur_pkg::PH_LENHI: begin
        len_nxt   = {rx_byte, 8'h00};
        cnt_nxt   = '0;
        crc_nxt   = crc_upd;
        phase_nxt = fur_pkg::PH_LENLO;
      end
      fur_pkg::PH_LENLO: begin
        len_nxt = len_full;
        crc_nxt = crc_upd;
        cnt_nxt = '0;
        if (len_full == 16'd0 || len_full > limit) begin
          res.kind  = fur_pkg::EV_LEN_REJECT;
          phase_nxt = fur_pkg::PH_SYNC1;
        end else begin
          phase_nxt = fur_pkg::PH_DATA;
        end
      end
      fur_pkg::PH_DATA: begin
        crc_nxt            = crc_upd;
        res.kind           = fur_pkg::EV_PAYLOAD;
        res.payload_byte   = rx_byte;
        res.payload_offset = 10'(cnt_r);
        cnt_nxt            = cnt_inc;
        if (16'(cnt_inc) >= len_r) phase_nxt = fur_pkg::PH_CRCHI;
      end
      fur_pkg::PH_CRCHI: begin
        crc_hi_nxt = rx_byte;
        phase_nxt  = fur_pkg::PH_CRCLO;
      end
      fur_pkg::PH_CRCLO: begin
        res.frame_length = len_r[10:0];
        if ({crc_hi_r, rx_byte} == crc_r) begin
          res.kind            = fur_pkg::EV_GOOD;
          res.flash_page_addr = 24'(addr_r);
          res.erase_first     = (ofs_r == '0);
          addr_nxt            = addr_sum[ADDR_WIDTH-1:0];
          ofs_nxt             = ofs_t2[OFS_W-1:0];
        end else begin
          res.kind = fur_pkg::EV_CRC_ERR;
        end
        phase_nxt = fur_pkg::PH_SYNC1;
      end
      default: begin
        phase_nxt = fur_pkg::PH_SYNC1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= fur_pkg::PH_SYNC1;
      len_r    <= '0;
      cnt_r    <= '0;
      crc_r    <= fur_pkg::CRC_INIT;
      crc_hi_r <= '0;
      addr_r   <= '0;
      ofs_r    <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      crc_r    <= crc_nxt;
      crc_hi_r <= crc_hi_nxt;
      addr_r   <= addr_nxt;
      ofs_r    <= ofs_nxt;
    end
  end

endmodule

// File: sv/framed_update_receiver_crc16.sv
// Path from an input transfer to the earliest output transfer: the input register,
// then parse/CRC logic into the output register.
// Throughput: 1 byte per cycle while out_ready stays high; the CRC byte update and
// phase logic sit in one stage. Reset (rst_n low, synchronous): hunt for first sync byte, CRC 0xFFFF,
// write address 0, max_payload_len 512, both stages empty.
module framed_update_receiver_crc16 #(
  parameter int LEN_LIMIT_MAX = 1024,
  parameter int PAGE_STRIDE   = 256,
  parameter int ERASE_BLOCK   = 4096,
  parameter int ADDR_WIDTH    = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_kind,
  output logic [7:0]  out_payload_byte,
  output logic [9:0]  out_payload_offset,
  output logic [10:0] out_frame_length,
  output logic [23:0] out_flash_page_addr,
  output logic        out_erase_first,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic                in_vld_r;
  logic [7:0]          in_byte_r;
  logic                out_vld_r;
  fur_pkg::fur_result_t out_res_r;
  fur_pkg::fur_result_t res;
  logic [10:0]         max_len_r;
  logic                advance;
  logic                cfg_wr;

  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
  end

  fur_parser #(
    .LEN_LIMIT_MAX(LEN_LIMIT_MAX),
    .PAGE_STRIDE  (PAGE_STRIDE),
    .ERASE_BLOCK  (ERASE_BLOCK),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .rx_byte(in_byte_r),
    .max_len(max_len_r),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_event_kind      = out_res_r.kind;
  assign out_payload_byte    = out_res_r.payload_byte;
  assign out_payload_offset  = out_res_r.payload_offset;
  assign out_frame_length    = out_res_r.frame_length;
  assign out_flash_page_addr = out_res_r.flash_page_addr;
  assign out_erase_first     = out_res_r.erase_first;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= fur_pkg::MAX_LEN_RST;
    end else if (cfg_wr && ({cfg_paddr[2], 2'b00} == fur_pkg::ADDR_MAX_LEN)) begin
      max_len_r <= cfg_pwdata[10:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = ({cfg_paddr[2], 2'b00} == fur_pkg::ADDR_MAX_LEN) ?
                      {21'b0, max_len_r} : 32'b0;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_vld_r && out_vld_r && !out_ready))
    else $error("input stalled without a blocked result");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_ready && !advance) |=> !out_vld_r)
    else $error("result repeated after its transfer");

  a_addr_only_good: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.kind != fur_pkg::EV_GOOD) |->
      (!out_res_r.erase_first && out_res_r.flash_page_addr == 24'd0))
    else $error("flash address on a non-good event");

  a_len_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_res_r.kind == fur_pkg::EV_GOOD ||
                   out_res_r.kind == fur_pkg::EV_CRC_ERR)) |->
      (out_res_r.frame_length != 11'd0 &&
       out_res_r.frame_length <= 11'(LEN_LIMIT_MAX)))
    else $error("finished frame length out of range");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int LEN_CAP     = 1024;
  localparam int STRIDE      = 256;
  localparam int ERASE_SPAN  = 4096;
  localparam int STALL_LIMIT = 2000;
  localparam int WHOLE       = 1 << 30;

  class frame_parse_tracker;
    fur_pkg::fur_phase_t  phase;
    logic [15:0]          frame_len;
    logic [15:0]          rx_count;
    logic [15:0]          crc_acc;
    logic [7:0]           crc_hi;
    logic [23:0]          page_addr;
    logic [10:0]          max_len;
    fur_pkg::fur_result_t event_q[$];
    int                   n_errors, n_checked, n_good, n_crc_bad, n_reject;

    function new();
      phase     = fur_pkg::PH_SYNC1;
      frame_len = '0;
      rx_count  = '0;
      crc_acc   = fur_pkg::CRC_INIT;
      crc_hi    = '0;
      page_addr = '0;
      max_len   = fur_pkg::MAX_LEN_RST;
      n_errors  = 0;
      n_checked = 0;
      n_good    = 0;
      n_crc_bad = 0;
      n_reject  = 0;
    endfunction

    // reflected CRC, one data bit per round
    static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] d);
      logic [15:0] r;
      logic        fb;
      r = c;
      for (int i = 0; i < 8; i++) begin
        fb = r[0] ^ d[i];
        r  = {1'b0, r[15:1]};
        if (fb) r = r ^ fur_pkg::CRC_POLY;
      end
      return r;
    endfunction

    function int eff_limit();
      return (max_len > LEN_CAP) ? LEN_CAP : int'(max_len);
    endfunction

    function int pending();
      return event_q.size();
    endfunction

    function void take_byte(logic [7:0] b);
      fur_pkg::fur_result_t r;
      r = '0;
      case (phase)
        fur_pkg::PH_SYNC1: if (b == fur_pkg::SYNC_FIRST) phase = fur_pkg::PH_SYNC2;
        fur_pkg::PH_SYNC2: if (b == fur_pkg::SYNC_SECOND) phase = fur_pkg::PH_LENHI;
        fur_pkg::PH_LENHI: begin
          frame_len = {b, 8'h00};
          rx_count  = '0;
          crc_acc   = crc_next(fur_pkg::CRC_INIT, b);
          phase     = fur_pkg::PH_LENLO;
        end
        fur_pkg::PH_LENLO: begin
          frame_len[7:0] = b;
          crc_acc        = crc_next(crc_acc, b);
          rx_count       = '0;
          if (frame_len == 0 || int'(frame_len) > eff_limit()) begin
            r.kind = fur_pkg::EV_LEN_REJECT;
            phase  = fur_pkg::PH_SYNC1;
            n_reject++;
          end else begin
            phase = fur_pkg::PH_DATA;
          end
        end
        fur_pkg::PH_DATA: begin
          crc_acc          = crc_next(crc_acc, b);
          r.kind           = fur_pkg::EV_PAYLOAD;
          r.payload_byte   = b;
          r.payload_offset = rx_count[9:0];
          rx_count         = rx_count + 16'd1;
          if (rx_count >= frame_len) phase = fur_pkg::PH_CRCHI;
        end
        fur_pkg::PH_CRCHI: begin
          crc_hi = b;
          phase  = fur_pkg::PH_CRCLO;
        end
        fur_pkg::PH_CRCLO: begin
          r.frame_length = frame_len[10:0];
          if ({crc_hi, b} == crc_acc) begin
            r.kind            = fur_pkg::EV_GOOD;
            r.flash_page_addr = page_addr;
            r.erase_first     = (page_addr % ERASE_SPAN) == 0;
            page_addr         = page_addr + STRIDE;
            n_good++;
          end else begin
            r.kind = fur_pkg::EV_CRC_ERR;
            n_crc_bad++;
          end
          phase = fur_pkg::PH_SYNC1;
        end
        default: phase = fur_pkg::PH_SYNC1;
      endcase
      event_q.push_back(r);
    endfunction

    function void check_event(fur_pkg::fur_result_t got);
      fur_pkg::fur_result_t exp;
      if (event_q.size() == 0) begin
        $error("result transfer with nothing pending: event_kind %0d", got.kind);
        n_errors++;
        return;
      end
      exp = event_q.pop_front();
      n_checked++;
      if (got.kind !== exp.kind) begin
        $error("event_kind: expected %0d, got %0d", exp.kind, got.kind);
        n_errors++;
      end
      if (got.payload_byte !== exp.payload_byte) begin
        $error("payload_byte: expected %0h, got %0h", exp.payload_byte, got.payload_byte);
        n_errors++;
      end
      if (got.payload_offset !== exp.payload_offset) begin
        $error("payload_offset: expected %0d, got %0d", exp.payload_offset,
               got.payload_offset);
        n_errors++;
      end
      if (got.frame_length !== exp.frame_length) begin
        $error("frame_length: expected %0d, got %0d", exp.frame_length, got.frame_length);
        n_errors++;
      end
      if (got.flash_page_addr !== exp.flash_page_addr) begin
        $error("flash_page_addr: expected %0h, got %0h", exp.flash_page_addr,
               got.flash_page_addr);
        n_errors++;
      end
      if (got.erase_first !== exp.erase_first) begin
        $error("erase_first: expected %0b, got %0b", exp.erase_first, got.erase_first);
        n_errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_event_kind;
  logic [7:0]  out_payload_byte;
  logic [9:0]  out_payload_offset;
  logic [10:0] out_frame_length;
  logic [23:0] out_flash_page_addr;
  logic        out_erase_first;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  frame_parse_tracker tracker = new();
  logic        calm = 1'b0;
  int          n_fed = 0;
  int          quiet_cycles = 0;
  int          last_limit;

  framed_update_receiver_crc16 #(
    .LEN_LIMIT_MAX(LEN_CAP),
    .PAGE_STRIDE  (STRIDE),
    .ERASE_BLOCK  (ERASE_SPAN),
    .ADDR_WIDTH   (24)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_kind     (out_event_kind),
    .out_payload_byte   (out_payload_byte),
    .out_payload_offset (out_payload_offset),
    .out_frame_length   (out_frame_length),
    .out_flash_page_addr(out_flash_page_addr),
    .out_erase_first    (out_erase_first),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 17);
  end

  // handshakes sampled mid-cycle; inputs only move at the rising edge
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_event(fur_pkg::fur_result_t'({out_event_kind, out_payload_byte,
                                                  out_payload_offset, out_frame_length,
                                                  out_flash_page_addr, out_erase_first}));
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    logic took;
    while (!calm && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do begin
      @(negedge clk);
      took = in_ready;
      if (took) tracker.take_byte(b);
      @(posedge clk);
    end while (!took);
    n_fed++;
  endtask

  // header only when the length will be refused; cut truncates the byte stream
  task automatic send_frame(input logic [15:0] len, input logic [15:0] crc_flip,
                            input int cut);
    logic [7:0]  seq[$];
    logic [15:0] c;
    logic [7:0]  d;
    seq.push_back(fur_pkg::SYNC_FIRST);
    seq.push_back(fur_pkg::SYNC_SECOND);
    seq.push_back(len[15:8]);
    seq.push_back(len[7:0]);
    c = frame_parse_tracker::crc_next(fur_pkg::CRC_INIT, len[15:8]);
    c = frame_parse_tracker::crc_next(c, len[7:0]);
    if (len != 0 && int'(len) <= tracker.eff_limit()) begin
      for (int i = 0; i < int'(len); i++) begin
        d = 8'($urandom_range(255));
        seq.push_back(d);
        c = frame_parse_tracker::crc_next(c, d);
      end
      c = c ^ crc_flip;
      seq.push_back(c[15:8]);
      seq.push_back(c[7:0]);
    end
    foreach (seq[i]) if (i < cut) push_byte(seq[i]);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_max_payload_len(input logic [10:0] v);
    logic done;
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= fur_pkg::ADDR_MAX_LEN;
    cfg_pwdata  <= {21'd0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do begin
      @(negedge clk);
      done = cfg_pready;
      @(posedge clk);
    end while (!done);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    tracker.max_len = v;
  endtask

  task automatic random_traffic(input int budget);
    int          stop_at;
    int          pick;
    int          lim;
    logic [15:0] len;
    logic [15:0] flip;
    stop_at = n_fed + budget;
    lim     = tracker.eff_limit();
    while (n_fed < stop_at) begin
      pick = $urandom_range(99);
      if (lim == 0 || pick < 10) begin
        len = ($urandom_range(1) == 0) ? 16'd0 : 16'($urandom_range(65535, lim + 1));
        send_frame(len, 16'd0, WHOLE);
      end else if (pick < 78 || pick >= 90) begin
        if ($urandom_range(99) < 2)
          len = 16'($urandom_range(lim, 1));
        else
          len = 16'($urandom_range((lim < 12) ? lim : 12, 1));
        flip = ($urandom_range(99) < 20) ? (16'd1 << $urandom_range(15)) : 16'd0;
        if (pick >= 90)
          send_frame(len, flip, $urandom_range(int'(len) + 5, 1));
        else
          send_frame(len, flip, WHOLE);
      end else begin
        if ($urandom_range(3) == 0) push_byte(fur_pkg::SYNC_FIRST);
        repeat ($urandom_range(6, 1)) push_byte(8'($urandom_range(255)));
      end
    end
    settle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // hunt noise, missing second sync byte, zero and oversize lengths, good and bad CRC
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(fur_pkg::SYNC_FIRST);
    push_byte(8'h13);
    send_frame(16'd0, 16'd0, WHOLE);
    send_frame(16'hFFFF, 16'd0, WHOLE);
    send_frame(16'd1, 16'd0, WHOLE);
    send_frame(16'd2, 16'h0001, WHOLE);
    settle();
    random_traffic(150);

    // one past the hard cap is refused
    set_max_payload_len(11'd1024);
    send_frame(16'd1025, 16'd0, WHOLE);
    random_traffic(120);

    // above the hard cap: clipped to it
    set_max_payload_len(11'd2047);
    send_frame(16'd1025, 16'd0, WHOLE);
    random_traffic(100);

    set_max_payload_len(11'd0);
    random_traffic(60);

    // minimal frames back to back with no idling on either side
    set_max_payload_len(11'd1);
    calm = 1'b1;
    repeat (20) send_frame(16'd1, 16'd0, WHOLE);
    calm = 1'b0;
    random_traffic(60);

    last_limit = $urandom_range(1023, 2);
    set_max_payload_len(11'(last_limit));
    random_traffic(200);

    $display("Run: %0d bytes in, %0d events checked", n_fed, tracker.n_checked);
    $display("%0d good frames, %0d CRC errors, %0d rejects; limits 512 1024 2047 0 1 %0d",
             tracker.n_good, tracker.n_crc_bad, tracker.n_reject, last_limit);
    if (tracker.n_errors == 0 && tracker.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
